>>> sv/gaussian_niche_suitability_macros.svh
// ----------------------------------------------------------------------------
// Gaussian niche suitability assertion macros
// Short forms for the concurrent checks of the top level, clocked on i_clk
// and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_NICHE_SUITABILITY_MACROS_SVH
`define GAUSSIAN_NICHE_SUITABILITY_MACROS_SVH

// Same-cycle implication.
`define GNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/gns_pkg.sv
// ----------------------------------------------------------------------------
// gns_pkg
// Shared types, constants and the exponential table builder of the
// Gaussian niche suitability block.
// ----------------------------------------------------------------------------
`default_nettype none

package gns_pkg;

    localparam int DEF_MAX_VARIABLES   = 16;
    localparam int DEF_EXP_TABLE_DEPTH = 256;

    // Largest exponential table the builder supports.
    localparam int ROM_AW      = 12;
    localparam int EXP_ROM_MAX = 1 << ROM_AW;

    localparam logic [15:0] ONE_Q15   = 16'h8000;
    localparam logic [31:0] ROUND_Q15 = 32'h0000_4000;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SQUARE,
        ST_SCALE,
        ST_LOOKUP,
        ST_PRODUCT
    } t_state;

    typedef enum logic [1:0] {
        MUL_SEL_LO,
        MUL_SEL_HI,
        MUL_SEL_SQ,
        MUL_SEL_PROD
    } t_mul_sel;

    typedef struct packed {
        logic     capture;
        logic     diff_en;
        t_mul_sel mul_sel;
        logic     lo_en;
        logic     hi_en;
        logic     sq_en;
        logic     scale_en;
        logic     lookup_en;
        logic     prod_en;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_status;

    typedef logic [15:0] t_exp_rom [0:EXP_ROM_MAX-1];

    // rom[k] ~ 32768*exp(-16k/depth), built in Q0.32 from a 12-term series.
    function automatic t_exp_rom build_exp_rom(input int unsigned depth,
                                               input logic [63:0] step);
        t_exp_rom    rom;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] p;
        int          n;
        int          k;
        rom  = '{default: '0};
        term = 64'd1 << 32;
        e    = term;
        p    = term;
        for (n = 1; n <= 12; n++) begin
            term = (term * step) >> 32;
            term = term / 64'(n);
            if ((n % 2) == 1) begin
                e = e - term;
            end else begin
                e = e + term;
            end
        end
        for (k = 0; k < int'(depth); k++) begin
            rom[k] = 16'((p + (64'd1 << 16)) >> 17);
            p      = (p * e + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

>>> sv/gns_ctrl.sv
// ----------------------------------------------------------------------------
// gns_ctrl
// Sequencer of the suitability datapath: takes one request at a time and
// steps an evaluate request through the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module gns_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_op,
    output logic                       o_stall,
    input  wire gns_pkg::t_dp_status   i_status,
    output gns_pkg::t_dp_cmd           o_cmd
);

    gns_pkg::t_state r_state;
    gns_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gns_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        o_cmd   = '0;
        o_cmd.mul_sel = gns_pkg::MUL_SEL_LO;
        case (r_state)
            gns_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_op == gns_pkg::OP_EVAL) begin
                        n_state = gns_pkg::ST_DIFF;
                    end
                end
            end
            gns_pkg::ST_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state = gns_pkg::ST_MUL_LO;
            end
            gns_pkg::ST_MUL_LO: begin
                o_cmd.mul_sel = gns_pkg::MUL_SEL_LO;
                o_cmd.lo_en   = 1'b1;
                n_state = gns_pkg::ST_MUL_HI;
            end
            gns_pkg::ST_MUL_HI: begin
                o_cmd.mul_sel = gns_pkg::MUL_SEL_HI;
                o_cmd.hi_en   = 1'b1;
                n_state = gns_pkg::ST_SQUARE;
            end
            gns_pkg::ST_SQUARE: begin
                o_cmd.mul_sel = gns_pkg::MUL_SEL_SQ;
                o_cmd.sq_en   = 1'b1;
                n_state = gns_pkg::ST_SCALE;
            end
            gns_pkg::ST_SCALE: begin
                o_cmd.scale_en = 1'b1;
                n_state = gns_pkg::ST_LOOKUP;
            end
            gns_pkg::ST_LOOKUP: begin
                o_cmd.lookup_en = 1'b1;
                n_state = gns_pkg::ST_PRODUCT;
            end
            gns_pkg::ST_PRODUCT: begin
                o_cmd.mul_sel = gns_pkg::MUL_SEL_PROD;
                // hold the last element until the output register can take it
                if (!i_status.last || i_status.out_free) begin
                    o_cmd.prod_en = 1'b1;
                    o_cmd.emit    = i_status.last;
                    n_state = gns_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gns_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/gns_datapath.sv
// ----------------------------------------------------------------------------
// gns_datapath
// Model tables, shared multiplier, exponential table, running product,
// threshold register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gns_datapath #(
    parameter int MAX_VARIABLES   = gns_pkg::DEF_MAX_VARIABLES,
    parameter int EXP_TABLE_DEPTH = gns_pkg::DEF_EXP_TABLE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gns_pkg::t_dp_cmd     i_cmd,
    output gns_pkg::t_dp_status       o_status,
    input  wire logic                 i_cfg_we,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_op,
    input  wire logic [3:0]           i_var_index,
    input  wire logic signed [31:0]   i_mean_value,
    input  wire logic [31:0]          i_std_inverse,
    input  wire logic signed [31:0]   i_sample_value,
    input  wire logic                 i_last_element,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [15:0]               o_suitability,
    output logic                      o_binary_mode
);

    localparam int AW = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
    localparam int RW = $clog2(EXP_TABLE_DEPTH);
    localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int SW = 38 + DW;
    localparam int IW = SW - 36;
    localparam logic [63:0] EXP_STEP = (64'd16 << 32) / 64'(EXP_TABLE_DEPTH);
    localparam gns_pkg::t_exp_rom EXP_ROM =
        gns_pkg::build_exp_rom(EXP_TABLE_DEPTH, EXP_STEP);

    logic [31:0] r_mean_mem [MAX_VARIABLES];
    logic [31:0] r_inv_mem  [MAX_VARIABLES];

    logic [31:0] r_mean_rd;
    logic [31:0] r_inv_rd;
    logic [31:0] r_sample;
    logic        r_in_range;
    logic        r_last;
    logic [32:0] r_mag;
    logic [31:0] r_pl_hi;
    logic [18:0] r_zq;
    logic        r_zbig;
    logic [36:0] r_u;
    logic [RW-1:0] r_idx;
    logic        r_idx_big;
    logic [15:0] r_factor;
    logic [15:0] r_prod;
    logic [15:0] r_threshold;
    logic        r_out_valid;
    logic [15:0] r_suitability;
    logic        r_binary_mode;

    logic          w_in_range;
    logic [AW-1:0] w_addr;
    logic [32:0]   w_diff;
    logic [32:0]   w_mag;
    logic [18:0]   w_mul_a;
    logic [31:0]   w_mul_b;
    logic [50:0]   w_mul;
    logic [49:0]   w_zsum;
    logic [SW-1:0] w_scaled;
    logic [IW-1:0] w_idx_full;
    logic [31:0]   w_round;
    logic [15:0]   w_prod_next;

    assign w_in_range = (32'(i_var_index) < 32'(MAX_VARIABLES));
    assign w_addr     = AW'(i_var_index);

    // table write on load, registered read on evaluate
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            if ((i_op == gns_pkg::OP_LOAD) && w_in_range) begin
                r_mean_mem[w_addr] <= i_mean_value;
                r_inv_mem[w_addr]  <= i_std_inverse;
            end
            r_mean_rd  <= r_mean_mem[w_addr];
            r_inv_rd   <= r_inv_mem[w_addr];
            r_sample   <= i_sample_value;
            r_in_range <= w_in_range;
            r_last     <= i_last_element;
        end
    end

    assign w_diff = {r_sample[31], r_sample} - {r_mean_rd[31], r_mean_rd};
    assign w_mag  = w_diff[32] ? (~w_diff + 33'd1) : w_diff;

    always_comb begin
        case (i_cmd.mul_sel)
            gns_pkg::MUL_SEL_LO: begin
                w_mul_a = {3'b000, r_mag[15:0]};
                w_mul_b = r_inv_rd;
            end
            gns_pkg::MUL_SEL_HI: begin
                w_mul_a = {2'b00, r_mag[32:16]};
                w_mul_b = r_inv_rd;
            end
            gns_pkg::MUL_SEL_SQ: begin
                w_mul_a = r_zq;
                w_mul_b = {13'd0, r_zq};
            end
            gns_pkg::MUL_SEL_PROD: begin
                w_mul_a = {3'b000, r_prod};
                w_mul_b = {16'd0, r_factor};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = 51'(w_mul_a) * 51'(w_mul_b);

    // |z| >> 16 from the two partial products
    assign w_zsum = 50'(w_mul[48:0]) + 50'(r_pl_hi);

    assign w_scaled   = SW'(r_u) * SW'(EXP_TABLE_DEPTH) + (SW'(1) << 35);
    assign w_idx_full = w_scaled[SW-1:36];

    assign w_round     = 32'(w_mul[30:0]) + gns_pkg::ROUND_Q15;
    assign w_prod_next = w_round[30:15];

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_en) begin
            r_mag <= w_mag;
        end
        if (i_cmd.lo_en) begin
            r_pl_hi <= w_mul[47:16];
        end
        if (i_cmd.hi_en) begin
            r_zq   <= w_zsum[18:0];
            r_zbig <= |w_zsum[49:19];
        end
        if (i_cmd.sq_en) begin
            r_u <= w_mul[37:1];
        end
        if (i_cmd.scale_en) begin
            r_idx     <= w_idx_full[RW-1:0];
            r_idx_big <= (w_idx_full >= IW'(EXP_TABLE_DEPTH));
        end
        if (i_cmd.lookup_en) begin
            if (!r_in_range) begin
                r_factor <= gns_pkg::ONE_Q15;
            end else if (r_zbig || r_idx_big) begin
                r_factor <= '0;
            end else begin
                r_factor <= EXP_ROM[gns_pkg::ROM_AW'(r_idx)];
            end
        end
        if (i_cmd.emit) begin
            if (!r_threshold[15]) begin
                r_suitability <= (w_prod_next < r_threshold) ? 16'd0 : gns_pkg::ONE_Q15;
                r_binary_mode <= 1'b1;
            end else begin
                r_suitability <= w_prod_next;
                r_binary_mode <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod      <= gns_pkg::ONE_Q15;
            r_threshold <= gns_pkg::ONE_Q15;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_data;
            end
            if (i_cmd.prod_en) begin
                r_prod <= r_last ? gns_pkg::ONE_Q15 : w_prod_next;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.last     = r_last;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_suitability = r_suitability;
    assign o_binary_mode = r_binary_mode;

endmodule

`default_nettype wire

>>> sv/gaussian_niche_suitability.sv
// ----------------------------------------------------------------------------
// gaussian_niche_suitability
// Gaussian niche model: per-variable mean and inverse deviation, product of
// exp(-z*z/2) factors over the elements of one sample point, Q1.15 result.
//
// Usage:
//   Input channel (i_valid / o_stall): a request is taken at a clock edge
//   with i_valid high and o_stall low. i_op = load writes the mean and the
//   inverse deviation of i_var_index; i_op = evaluate folds one element of
//   a sample point into the running product.
//   Output channel (o_valid / i_stall): one result per evaluate request
//   with i_last_element set, taken when o_valid is high and i_stall low.
//   Config: i_cfg_we writes i_cfg_data into the threshold; below 1.0 the
//   result becomes 0 or 1.0 and o_binary_mode is set.
//   Sequence: a load is written at the edge that takes it. An evaluate steps
//   through request cycle, subtract, two partial products of |d|*inv_std,
//   square, index scale, table read and product on the one shared 19x32
//   multiplier; the result shows on o_valid the cycle after the product step.
//   Stall: the result waits in the output register while the next requests
//   run; a last element whose result register is still full holds in the
//   product step until the receiver takes the older result.
//   Reset: clears the running product to 1.0 and the threshold to 1.0 and
//   drops any pending result; the model tables keep their contents.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_niche_suitability_macros.svh"

module gaussian_niche_suitability #(
    parameter int MAX_VARIABLES   = gns_pkg::DEF_MAX_VARIABLES,
    parameter int EXP_TABLE_DEPTH = gns_pkg::DEF_EXP_TABLE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    // request channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_op,
    input  wire logic [3:0]         i_var_index,
    input  wire logic signed [31:0] i_mean_value,
    input  wire logic [31:0]        i_std_inverse,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic               i_last_element,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_suitability,
    output logic                    o_binary_mode
);

    gns_pkg::t_dp_cmd    w_cmd;
    gns_pkg::t_dp_status w_status;

    // Sequencer: one request in flight, drives the datapath step by step.
    gns_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Tables, shared multiplier, exp table and the output register.
    gns_datapath #(
        .MAX_VARIABLES   (MAX_VARIABLES),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_var_index    (i_var_index),
        .i_mean_value   (i_mean_value),
        .i_std_inverse  (i_std_inverse),
        .i_sample_value (i_sample_value),
        .i_last_element (i_last_element),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_suitability  (o_suitability),
        .o_binary_mode  (o_binary_mode)
    );

    // A request is captured only while the input side is open.
    `GNS_ASSERT_NOW(a_capture_open, w_cmd.capture, !o_stall, "capture while stalled")

    // Never overwrite a result that the receiver has not taken.
    `GNS_ASSERT_NOW(a_emit_free, w_cmd.emit, !o_valid || !i_stall, "result overwritten")

    // A new result follows a product step of a last element.
    `GNS_ASSERT_NOW(a_valid_source, $rose(o_valid), $past(w_cmd.emit), "result without emit")

    // Thresholded output is either zero or one.
    `GNS_ASSERT_NOW(a_binary_value, o_valid && o_binary_mode,
        (o_suitability == 16'd0) || (o_suitability == 16'h8000), "binary value out of set")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gaussian niche suitability block. A queue of
// load and evaluate requests feeds a clocked driver, and each accepted
// request is folded into a bit-exact predictor of the running product and
// threshold. A clocked monitor compares every result with the oldest
// predicted one. Random idling on both channels, one long receiver hold,
// and a run through several threshold settings.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int NUM_VARS    = gns_pkg::DEF_MAX_VARIABLES;
    localparam int EXP_DEPTH   = gns_pkg::DEF_EXP_TABLE_DEPTH;
    // Settle for longer than an evaluate runs before a write.
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AFTER  = 400;
    localparam int PHASE_ITEMS = 225;

    typedef struct {
        gns_pkg::t_op op;
        logic [3:0]   var_idx;
        logic [31:0]  mean;
        logic [31:0]  inv_std;
        logic [31:0]  sample;
        logic         last;
    } t_niche_req;

    typedef struct {
        logic [15:0] suitability;
        logic        binary;
    } t_niche_result;

    // DUT ports
    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic               i_op;
    logic [3:0]         i_var_index;
    logic signed [31:0] i_mean_value;
    logic [31:0]        i_std_inverse;
    logic signed [31:0] i_sample_value;
    logic               i_last_element;
    logic               o_valid;
    logic               i_stall;
    logic [15:0]        o_suitability;
    logic               o_binary_mode;

    gaussian_niche_suitability DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_var_index    (i_var_index),
        .i_mean_value   (i_mean_value),
        .i_std_inverse  (i_std_inverse),
        .i_sample_value (i_sample_value),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_suitability  (o_suitability),
        .o_binary_mode  (o_binary_mode)
    );

    // Request stream and predicted results.
    t_niche_req    pending_requests[$];
    t_niche_result suitability_q[$];

    // Predictor state: model tables, exp table, running product, threshold.
    logic [31:0] model_mean[NUM_VARS];
    logic [31:0] model_inv_std[NUM_VARS];
    logic [15:0] gauss_rom[EXP_DEPTH];
    logic [31:0] point_product;
    logic [15:0] cfg_threshold;

    // Generator view of the tables, used to aim samples near the mean.
    logic [31:0]         gen_mean[NUM_VARS];
    logic [31:0]         gen_inv_std[NUM_VARS];
    logic [NUM_VARS-1:0] gen_loaded;

    int  cycle_count;
    int  fail_count;
    int  taken_requests;
    bit  calm_tail;
    bit  long_hold_done;
    int  send_gap_left;
    int  send_idle_pct;
    int  recv_hold_left;
    int  recv_idle_pct;
    t_niche_req cur_req;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Build the Q1.15 exp table: step ratio from a 12-term series in Q0.32,
    // then repeated multiplication with rounding.
    task automatic build_gauss_rom();
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] acc;
        step  = (64'd16 << 32) / 64'(EXP_DEPTH);
        term  = 64'd1 << 32;
        ratio = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * step) >> 32) / 64'(n);
            if (n % 2 == 1) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        acc = 64'd1 << 32;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            gauss_rom[k] = 16'((acc + (64'd1 << 16)) >> 17);
            acc          = (acc * ratio + (64'd1 << 31)) >> 32;
        end
    endtask

    // exp(-z*z/2) factor in Q1.15 for one element.
    function automatic logic [15:0] gauss_weight(input logic [31:0] mean,
                                                 input logic [31:0] inv_std,
                                                 input logic [31:0] sample);
        logic signed [63:0] diff;
        logic [63:0]        mag;
        logic [63:0]        z_mag;
        logic [63:0]        z_q16;
        logic [63:0]        half_sq;
        logic [63:0]        rom_idx;
        diff = $signed(sample);
        diff = diff - $signed(mean);
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        z_mag = mag * {32'd0, inv_std};
        if (z_mag >= (64'd8 << 32)) begin
            return 16'd0;
        end
        z_q16   = z_mag >> 16;
        half_sq = (z_q16 * z_q16) >> 1;
        rom_idx = (half_sq * 64'(EXP_DEPTH) + (64'd1 << 35)) >> 36;
        if (rom_idx >= 64'(EXP_DEPTH)) begin
            return 16'd0;
        end
        return gauss_rom[rom_idx];
    endfunction

    // Fold one accepted request into the predictor; queue a result on the
    // last element of a point.
    task automatic predict_suitability(input t_niche_req r);
        logic [31:0]   factor;
        t_niche_result res;
        if (r.op == gns_pkg::OP_LOAD) begin
            if (int'(r.var_idx) < NUM_VARS) begin
                model_mean[r.var_idx]    = r.mean;
                model_inv_std[r.var_idx] = r.inv_std;
            end
        end else begin
            factor = 32'h8000;
            if (int'(r.var_idx) < NUM_VARS) begin
                factor = {16'd0, gauss_weight(model_mean[r.var_idx],
                                              model_inv_std[r.var_idx], r.sample)};
            end
            point_product = (point_product * factor + 32'd16384) >> 15;
            if (r.last) begin
                if (cfg_threshold < 16'h8000) begin
                    res.suitability = (point_product[15:0] < cfg_threshold) ?
                                      16'd0 : 16'h8000;
                    res.binary      = 1'b1;
                end else begin
                    res.suitability = point_product[15:0];
                    res.binary      = 1'b0;
                end
                point_product = 32'h8000;
                suitability_q.push_back(res);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_load(input logic [3:0] v, input logic [31:0] mean,
                             input logic [31:0] inv_std, input logic lst);
        t_niche_req r;
        r.op      = gns_pkg::OP_LOAD;
        r.var_idx = v;
        r.mean    = mean;
        r.inv_std = inv_std;
        r.sample  = $urandom;
        r.last    = lst;
        pending_requests.push_back(r);
        gen_mean[v]    = mean;
        gen_inv_std[v] = inv_std;
        gen_loaded[v]  = 1'b1;
    endtask

    task automatic push_eval(input logic [3:0] v, input logic [31:0] sample,
                             input logic lst);
        t_niche_req r;
        r.op      = gns_pkg::OP_EVAL;
        r.var_idx = v;
        r.mean    = $urandom;
        r.inv_std = $urandom;
        r.sample  = sample;
        r.last    = lst;
        pending_requests.push_back(r);
    endtask

    // Mostly moderate deviations, some zero, tiny or fully random ones.
    function automatic logic [31:0] pick_inv_std();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return 32'd0;
        end else if (roll <= 2) begin
            return $urandom;
        end else if (roll == 3) begin
            return $urandom_range(1, 4095);
        end
        return $urandom_range(32'h0000_1000, 32'h0008_0000);
    endfunction

    // Sample a few deviations off the mean so the factor stays meaningful.
    function automatic logic [31:0] near_sample(input logic [3:0] v);
        logic [31:0] z_target;
        logic [63:0] offset;
        if (gen_inv_std[v] < 32'd4096) begin
            return $urandom;
        end
        if ($urandom_range(0, 9) == 0) begin
            z_target = $urandom_range(0, 6 << 16);
        end else begin
            z_target = $urandom_range(0, 3 << 15);
        end
        offset = ({32'd0, z_target} << 16) / {32'd0, gen_inv_std[v]};
        if ($urandom_range(0, 1) == 1) begin
            return gen_mean[v] + offset[31:0];
        end
        return gen_mean[v] - offset[31:0];
    endfunction

    function automatic logic [3:0] pick_loaded_var();
        logic [3:0] v;
        v = 4'($urandom_range(0, NUM_VARS - 1));
        while (!gen_loaded[v]) begin
            v = 4'($urandom_range(0, NUM_VARS - 1));
        end
        return v;
    endfunction

    // Well-formed points with random content, plus reloads, loads dropped
    // into the middle of a point and stray elements with random samples.
    task automatic queue_niche_traffic(input int n_items);
        int         queued;
        int         roll;
        int         n_elem;
        logic [3:0] v;
        queued = 0;
        while (queued < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                repeat ($urandom_range(1, 3)) begin
                    push_load(4'($urandom_range(0, NUM_VARS - 1)), $urandom,
                              pick_inv_std(), 1'($urandom_range(0, 1)));
                    queued++;
                end
            end else if (roll < 20) begin
                push_eval(pick_loaded_var(), $urandom, 1'($urandom_range(0, 1)));
                queued++;
            end else begin
                n_elem = $urandom_range(1, 6);
                for (int e = 0; e < n_elem; e++) begin
                    if (e > 0 && $urandom_range(0, 15) == 0) begin
                        push_load(4'($urandom_range(0, NUM_VARS - 1)), $urandom,
                                  pick_inv_std(), 1'($urandom_range(0, 1)));
                        queued++;
                    end
                    v = pick_loaded_var();
                    push_eval(v, near_sample(v), e == n_elem - 1);
                    queued++;
                end
            end
        end
    endtask

    // Hold until every request is taken and every result has come back, then
    // let the pipeline settle in case the last request was a non-final element.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || i_valid || suitability_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_data    <= value;
        cfg_threshold  = value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Request driver: pop the queue, hold a stalled request, insert gaps
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            send_gap_left  = 0;
        end else begin
            if (cycle_count % 128 == 0) begin
                case ($urandom_range(0, 2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 8;
                    default: send_idle_pct = 35;
                endcase
            end
            // Fold the request taken at this edge before picking the next.
            if (i_valid && !o_stall) begin
                predict_suitability(cur_req);
                taken_requests++;
            end
            if (i_valid && o_stall) begin
                // hold the stalled request as it is
            end else if (send_gap_left > 0) begin
                send_gap_left--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                if (!calm_tail && $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap_left = $urandom_range(1, 13) - 1;
                    i_valid      <= 1'b0;
                end else begin
                    cur_req         = pending_requests.pop_front();
                    i_valid        <= 1'b1;
                    i_op           <= cur_req.op;
                    i_var_index    <= cur_req.var_idx;
                    i_mean_value   <= cur_req.mean;
                    i_std_inverse  <= cur_req.inv_std;
                    i_sample_value <= cur_req.sample;
                    i_last_element <= cur_req.last;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: random bursts, one long hold to back the block up
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall        <= 1'b0;
            recv_hold_left  = 0;
        end else begin
            if (cycle_count % 128 == 64) begin
                case ($urandom_range(0, 2))
                    0: recv_idle_pct = 0;
                    1: recv_idle_pct = 10;
                    default: recv_idle_pct = 40;
                endcase
            end
            if (!long_hold_done && taken_requests >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                recv_hold_left = LONG_HOLD;
            end
            if (recv_hold_left > 0) begin
                recv_hold_left--;
                i_stall <= 1'b1;
            end else if (calm_tail) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                recv_hold_left = $urandom_range(1, 13) - 1;
                i_stall       <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_niche_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (suitability_q.size() == 0) begin
                $error("unexpected result: suitability=%0d binary_mode=%0b",
                       o_suitability, o_binary_mode);
                fail_count++;
            end else begin
                exp_res = suitability_q.pop_front();
                if (o_suitability !== exp_res.suitability) begin
                    $error("suitability: expected %0d, actual %0d",
                           exp_res.suitability, o_suitability);
                    fail_count++;
                end
                if (o_binary_mode !== exp_res.binary) begin
                    $error("binary_mode: expected %0b, actual %0b",
                           exp_res.binary, o_binary_mode);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Cycle counter and timeout
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] phase_thr[8];
        phase_thr = '{16'h8000, 16'h0000, 16'h4E20, 16'h7FFF,
                      16'hFFFF, 16'h0001, 16'h0000, 16'h8000};
        phase_thr[6] = 16'($urandom_range(0, 16'hFFFF));

        cycle_count    = 0;
        fail_count     = 0;
        taken_requests = 0;
        calm_tail      = 1'b0;
        long_hold_done = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        gen_loaded     = '0;
        point_product  = 32'h8000;
        cfg_threshold  = 16'h8000;
        for (int i = 0; i < NUM_VARS; i++) begin
            model_mean[i]    = '0;
            model_inv_std[i] = '0;
            gen_mean[i]      = '0;
            gen_inv_std[i]   = '0;
        end
        build_gauss_rom();

        // Drive every input to a known value while reset is held, then release it.
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_op           = gns_pkg::OP_LOAD;
        i_var_index    = '0;
        i_mean_value   = '0;
        i_std_inverse  = '0;
        i_sample_value = '0;
        i_last_element = 1'b0;
        i_stall        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, zero deviation, z at and past the table
        // end, a load marked last, a load in the middle of a point.
        push_load(4'd0,  32'h0000_0000, 32'h0001_0000, 1'b0);
        push_load(4'd15, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_load(4'd1,  32'h8000_0000, 32'h0000_0000, 1'b0);
        push_load(4'd2,  32'h0001_0000, 32'h0001_0000, 1'b0);
        push_eval(4'd0,  32'h0000_0000, 1'b1);
        push_eval(4'd15, 32'h8000_0000, 1'b1);
        push_eval(4'd1,  32'h7FFF_FFFF, 1'b1);
        push_eval(4'd2,  32'h0002_0000, 1'b1);
        push_eval(4'd0,  32'hFFFF_0000, 1'b1);
        push_eval(4'd0,  32'h0008_0000, 1'b1);
        push_eval(4'd0,  32'h0007_FFFF, 1'b1);
        push_eval(4'd0,  32'h0005_A000, 1'b1);
        push_eval(4'd0,  32'h0000_8000, 1'b0);
        push_eval(4'd2,  32'h0000_0000, 1'b0);
        push_load(4'd3,  32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
        push_eval(4'd3,  32'h0000_0000, 1'b1);
        push_eval(4'd15, 32'h7FFF_FFFF, 1'b1);

        // Load the whole table so random points may touch any variable.
        wait_drained();
        for (int i = 0; i < NUM_VARS; i++) begin
            push_load(4'(i), $urandom, pick_inv_std(), 1'($urandom_range(0, 1)));
        end

        // Random phases, one threshold each; the last runs without idling.
        for (int p = 0; p < 8; p++) begin
            write_threshold(phase_thr[p]);
            if (p == 7) begin
                calm_tail = 1'b1;
            end
            queue_niche_traffic(PHASE_ITEMS);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
